[rtl/core/tlvd_pkg.sv]
// tlvd_pkg: shared types, codes and helper functions for the tlv entry deframer
// used by tlvd_front, tlvd_back, tlv_entry_deframer and the port checker
`default_nettype none

package tlvd_pkg;

    // type byte layout
    localparam logic [7:0] ID_WIDE_BIT     = 8'h20;
    localparam logic [2:0] INLINE_LEN_MASK = 3'd7;
    localparam logic [1:0] LEN_SIZE_MASK   = 2'd3;

    // queue between front and back, and result buffer
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 2;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_ID,
        PH_LEN,
        PH_VALUE
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HDR_BYTE = 3'd0,
        KIND_HDR_DONE = 3'd1,
        KIND_VALUE    = 3'd2,
        KIND_CLEAN    = 3'd3,
        KIND_TRUNC    = 3'd4
    } t_kind;

    // item classes after the front has dropped idle transactions
    typedef enum logic [1:0] {
        CLS_BYTE,
        CLS_BYTE_END,
        CLS_END
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [1:0]         id_kind;
        logic [15:0]        entry_id;
        logic [23:0]        value_length;
        logic [7:0]         value_byte;
        logic               value_last;
        logic signed [63:0] int_value;
        logic               int_valid;
    } t_result;

    // codes 2 and 3 both mean resource
    function automatic logic [1:0] id_kind_of(input logic [1:0] type_hi);
        return type_hi[1] ? 2'd2 : type_hi;
    endfunction

    function automatic logic int_len_ok(input logic [23:0] len);
        return (len == 24'd1) || (len == 24'd2) || (len == 24'd4) || (len == 24'd8);
    endfunction

endpackage

`default_nettype wire

[rtl/core/tlvd_front.sv]
// tlvd_front: accepts input transactions, drops idle ones, classifies the rest
// and holds them in a short queue for the back end; depends on tlvd_pkg
`default_nettype none

module tlvd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic           i_has_byte,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_message_end,
    output logic                o_item_valid,
    output tlvd_pkg::t_item     o_item,
    input  wire logic           i_item_take
);
    import tlvd_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count, n_count;
    logic                w_wr_en;
    logic                w_rd_en;
    t_item               w_item;

    // classify the transaction
    always_comb begin
        w_item.data = i_data_byte;
        case ({i_has_byte, i_message_end})
            2'b10:   w_item.cls = CLS_BYTE;
            2'b11:   w_item.cls = CLS_BYTE_END;
            default: w_item.cls = CLS_END;
        endcase
    end

    assign full         = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign w_wr_en      = push && !full && (i_has_byte || i_message_end);
    assign o_item_valid = (r_count != '0);
    assign w_rd_en      = i_item_take && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_wr_en && !w_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (!w_wr_en && w_rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tlvd_back.sv]
// tlvd_back: tlv parsing state machine and two-entry result buffer
// takes classified items from tlvd_front; depends on tlvd_pkg
`default_nettype none

module tlvd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_item_valid,
    input  wire tlvd_pkg::t_item i_item,
    output logic                 o_item_take,
    input  wire logic            pop,
    output logic                 empty,
    output tlvd_pkg::t_result    o_result
);
    import tlvd_pkg::*;

    t_phase       r_phase,     n_phase;
    logic [1:0]   r_type_hi,   n_type_hi;
    logic [15:0]  r_id_accum,  n_id_accum;
    logic [1:0]   r_id_left,   n_id_left;
    logic [23:0]  r_len_accum, n_len_accum;
    logic [1:0]   r_len_left,  n_len_left;
    logic [23:0]  r_val_left,  n_val_left;
    logic [63:0]  r_int,       n_int;

    t_result      r_out [OUT_DEPTH];
    logic [OUT_AW-1:0] r_out_wr, r_out_rd;
    logic [OUT_AW:0]   r_out_count;

    logic         w_proc;
    logic         w_pop;
    logic         w_has;
    logic         w_end;
    logic [7:0]   w_data;
    t_kind        w_kind;
    logic [7:0]   w_vbyte;
    logic         w_last;
    logic         w_ivalid;
    logic [23:0]  w_val_dec;
    t_result      w_res;

    assign w_proc      = i_item_valid && (r_out_count != (OUT_AW+1)'(OUT_DEPTH));
    assign o_item_take = w_proc;
    assign w_has       = (i_item.cls != CLS_END);
    assign w_end       = (i_item.cls != CLS_BYTE);
    assign w_data      = i_item.data;
    assign w_val_dec   = r_val_left - 24'd1;

    // next state and result
    always_comb begin
        n_phase     = r_phase;
        n_type_hi   = r_type_hi;
        n_id_accum  = r_id_accum;
        n_id_left   = r_id_left;
        n_len_accum = r_len_accum;
        n_len_left  = r_len_left;
        n_val_left  = r_val_left;
        n_int       = r_int;
        w_kind      = KIND_HDR_BYTE;
        w_vbyte     = 8'd0;
        w_last      = 1'b0;
        w_ivalid    = 1'b0;
        if (w_proc && w_has) begin
            case (r_phase)
                PH_TYPE: begin
                    n_type_hi  = w_data[7:6];
                    n_id_accum = 16'd0;
                    n_id_left  = ((w_data & ID_WIDE_BIT) != 8'd0) ? 2'd2 : 2'd1;
                    n_len_left = w_data[4:3] & LEN_SIZE_MASK;
                    n_len_accum = (n_len_left == 2'd0)
                                  ? {21'd0, w_data[2:0] & INLINE_LEN_MASK} : 24'd0;
                    n_val_left = 24'd0;
                    n_int      = 64'd0;
                    n_phase    = PH_ID;
                end
                PH_ID: begin
                    n_id_accum = {r_id_accum[7:0], w_data};
                    n_id_left  = r_id_left - 2'd1;
                    if (n_id_left == 2'd0) begin
                        if (r_len_left != 2'd0) begin
                            n_phase = PH_LEN;
                        end else begin
                            w_kind     = KIND_HDR_DONE;
                            n_val_left = r_len_accum;
                            n_int      = 64'd0;
                            w_last     = (r_len_accum == 24'd0);
                            n_phase    = (r_len_accum == 24'd0) ? PH_TYPE : PH_VALUE;
                        end
                    end
                end
                PH_LEN: begin
                    n_len_accum = {r_len_accum[15:0], w_data};
                    n_len_left  = r_len_left - 2'd1;
                    if (n_len_left == 2'd0) begin
                        w_kind     = KIND_HDR_DONE;
                        n_val_left = n_len_accum;
                        n_int      = 64'd0;
                        w_last     = (n_len_accum == 24'd0);
                        n_phase    = (n_len_accum == 24'd0) ? PH_TYPE : PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    // first value byte starts the sign extension
                    if (r_val_left == r_len_accum) begin
                        n_int = {{56{w_data[7]}}, w_data};
                    end else begin
                        n_int = {r_int[55:0], w_data};
                    end
                    w_kind     = KIND_VALUE;
                    w_vbyte    = w_data;
                    n_val_left = w_val_dec;
                    if (w_val_dec == 24'd0) begin
                        w_last   = 1'b1;
                        w_ivalid = int_len_ok(r_len_accum);
                        n_phase  = PH_TYPE;
                    end
                end
                default: begin
                    n_phase = PH_TYPE;
                end
            endcase
        end
        if (w_proc && w_end) begin
            if (n_phase != PH_TYPE) begin
                w_kind   = KIND_TRUNC;
                w_vbyte  = 8'd0;
                w_last   = 1'b0;
                w_ivalid = 1'b0;
                n_phase  = PH_TYPE;
            end else if (!w_has) begin
                w_kind = KIND_CLEAN;
            end
        end
        w_res.kind         = w_kind;
        w_res.id_kind      = id_kind_of(n_type_hi);
        w_res.entry_id     = n_id_accum;
        w_res.value_length = n_len_accum;
        w_res.value_byte   = w_vbyte;
        w_res.value_last   = w_last;
        w_res.int_value    = n_int;
        w_res.int_valid    = w_ivalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_type_hi   <= '0;
            r_id_accum  <= '0;
            r_id_left   <= '0;
            r_len_accum <= '0;
            r_len_left  <= '0;
            r_val_left  <= '0;
            r_int       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_type_hi   <= n_type_hi;
            r_id_accum  <= n_id_accum;
            r_id_left   <= n_id_left;
            r_len_accum <= n_len_accum;
            r_len_left  <= n_len_left;
            r_val_left  <= n_val_left;
            r_int       <= n_int;
        end
    end

    // result buffer
    assign empty    = (r_out_count == '0);
    assign w_pop    = pop && !empty;
    assign o_result = r_out[r_out_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr    <= '0;
            r_out_rd    <= '0;
            r_out_count <= '0;
        end else begin
            if (w_proc) begin
                r_out_wr <= r_out_wr + 1'b1;
            end
            if (w_pop) begin
                r_out_rd <= r_out_rd + 1'b1;
            end
            if (w_proc && !w_pop) begin
                r_out_count <= r_out_count + 1'b1;
            end else if (!w_proc && w_pop) begin
                r_out_count <= r_out_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out[r_out_wr] <= w_res;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tlv_entry_deframer.sv]
// a result passes through the front queue and then the result buffer before it shows on the result ports
// throughput: one transaction per cycle while neither queue is full, set by the parse step in tlvd_back
// a four-entry queue sits between front and back, a two-entry buffer on the results
// idle transactions (no byte, no end) are taken and give no result
// reset (synchronous, active low) empties both queues and returns the parser to
// waiting for a type byte with all counters and accumulators at zero
`default_nettype none

module tlv_entry_deframer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input side
    input  wire logic               push,
    output logic                    full,
    input  wire logic               i_has_byte,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_message_end,
    // result side
    output logic                    empty,
    input  wire logic               pop,
    output logic [2:0]              o_kind,
    output logic [1:0]              o_id_kind,
    output logic [15:0]             o_entry_id,
    output logic [23:0]             o_value_length,
    output logic [7:0]              o_value_byte,
    output logic                    o_value_last,
    output logic signed [63:0]      o_int_value,
    output logic                    o_int_valid
);
    import tlvd_pkg::*;

    // classified item travelling from front to back
    logic    w_item_valid;
    t_item   w_item;
    logic    w_item_take;
    t_result w_result;

    // front: handshake, idle drop and classification into the queue
    tlvd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_has_byte    (i_has_byte),
        .i_data_byte   (i_data_byte),
        .i_message_end (i_message_end),
        .o_item_valid  (w_item_valid),
        .o_item        (w_item),
        .i_item_take   (w_item_take)
    );

    // back: header decode, value counting, integer build and result buffer
    tlvd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_take  (w_item_take),
        .pop          (pop),
        .empty        (empty),
        .o_result     (w_result)
    );

    // unpack the head result onto its ports
    assign o_kind         = w_result.kind;
    assign o_id_kind      = w_result.id_kind;
    assign o_entry_id     = w_result.entry_id;
    assign o_value_length = w_result.value_length;
    assign o_value_byte   = w_result.value_byte;
    assign o_value_last   = w_result.value_last;
    assign o_int_value    = w_result.int_value;
    assign o_int_valid    = w_result.int_valid;

endmodule

`default_nettype wire

[rtl/core/tlvd_checker.sv]
// tlvd_checker: port-level assertions for tlv_entry_deframer, bound to the top level
// depends on tlvd_pkg
`default_nettype none

module tlvd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic [2:0]         o_kind,
    input wire logic [23:0]        o_value_length,
    input wire logic [7:0]         o_value_byte,
    input wire logic               o_value_last,
    input wire logic signed [63:0] o_int_value,
    input wire logic               o_int_valid
);
    import tlvd_pkg::*;

    // the result buffer is empty and the input queue is not full straight after reset
    a_reset_empty : assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // a stalled result holds
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_int_value)))
        else $error("waiting result changed");

    // only value transactions carry a value byte or a valid integer
    a_value_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != KIND_VALUE) |-> (o_value_byte == 8'd0 && !o_int_valid))
        else $error("value fields set on a non-value result");

    // a valid integer only on the last byte of a 1, 2, 4 or 8 byte value
    a_int_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_int_valid) |-> (o_value_last &&
            (o_value_length == 24'd1 || o_value_length == 24'd2 ||
             o_value_length == 24'd4 || o_value_length == 24'd8)))
        else $error("integer flagged valid at a bad length");

endmodule

bind tlv_entry_deframer tlvd_checker u_tlvd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_kind         (o_kind),
    .o_value_length (o_value_length),
    .o_value_byte   (o_value_byte),
    .o_value_last   (o_value_last),
    .o_int_value    (o_int_value),
    .o_int_valid    (o_int_valid)
);

`default_nettype wire
